// ===== hdl/tdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsd_pkg
// Types, constants and font table of the three-digit status display.
// ----------------------------------------------------------------------------
package tdsd_pkg;

   localparam int HOLD_COUNTER_BITS = 16;
   localparam int HOLD_CMP_BITS = (HOLD_COUNTER_BITS > 16) ? HOLD_COUNTER_BITS : 16;

   // configuration register indexes
   localparam logic [1:0] CSR_WARN_HOLD = 2'd0;
   localparam logic [1:0] CSR_SHOW_HOLD = 2'd1;
   localparam logic [1:0] CSR_HIGH_LIMIT = 2'd2;
   localparam logic [1:0] CSR_LOW_LIMIT = 2'd3;

   localparam logic [15:0] WARN_HOLD_RESET = 16'd1000;
   localparam logic [15:0] SHOW_HOLD_RESET = 16'd1500;
   localparam logic [9:0] HIGH_LIMIT_RESET = 10'd340;
   localparam logic [9:0] LOW_LIMIT_RESET = 10'd200;

   localparam logic [9:0] VOLT_MAX = 10'd999;
   localparam logic [6:0] DUTY_MAX = 7'd99;
   localparam logic [3:0] POWER_MAX = 4'd9;

   // panel modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_LEVEL = 2'd1;
   localparam logic [1:0] MODE_PULSE = 2'd2;

   // font indexes
   localparam logic [5:0] FONT_DASH = 6'd10;
   localparam logic [5:0] FONT_DOT = 6'd11;
   localparam logic [5:0] FONT_D = 6'd15;
   localparam logic [5:0] FONT_H = 6'd19;
   localparam logic [5:0] FONT_I = 6'd20;
   localparam logic [5:0] FONT_L = 6'd23;
   localparam logic [5:0] FONT_O = 6'd26;
   localparam logic [5:0] FONT_P = 6'd27;
   localparam logic [5:0] FONT_S = 6'd30;
   localparam logic [5:0] FONT_BLANK = 6'd38;

   localparam logic [7:0] PATTERN0_RESET = 8'd1;
   localparam logic [7:0] PATTERN1_RESET = 8'd2;
   localparam logic [7:0] PATTERN2_RESET = 8'd3;

   localparam logic [1:0] SCAN_LAST = 2'd2;

   typedef enum logic [1:0] {
      SCREEN_VOLT = 2'd0,
      SCREEN_DUTY = 2'd1,
      SCREEN_HIGH = 2'd2,
      SCREEN_LOW = 2'd3
   } screen_type;

   typedef struct packed {
      logic [9:0] volt_tenths;
      logic [6:0] duty_percent;
      logic [3:0] power_level;
      logic [3:0] pulse_count;
      logic [1:0] panel_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [2:0] digit_enable_n;
   } rsp_type;

   function automatic logic [7:0] font(input logic [5:0] idx);
      logic [7:0] pat;
      case (idx)
         6'd0: pat = 8'h3F;
         6'd1: pat = 8'h06;
         6'd2: pat = 8'h5B;
         6'd3: pat = 8'h4F;
         6'd4: pat = 8'h66;
         6'd5: pat = 8'h6D;
         6'd6: pat = 8'h7D;
         6'd7: pat = 8'h07;
         6'd8: pat = 8'h7F;
         6'd9: pat = 8'h6F;
         6'd10: pat = 8'h40;
         6'd11: pat = 8'h80;
         6'd12: pat = 8'h77;
         6'd13: pat = 8'h7C;
         6'd14: pat = 8'h39;
         6'd15: pat = 8'h5E;
         6'd16: pat = 8'h79;
         6'd17: pat = 8'h71;
         6'd18: pat = 8'h3D;
         6'd19: pat = 8'h76;
         6'd20: pat = 8'h06;
         6'd21: pat = 8'h1E;
         6'd22: pat = 8'h75;
         6'd23: pat = 8'h38;
         6'd24: pat = 8'h37;
         6'd25: pat = 8'h54;
         6'd26: pat = 8'h5C;
         6'd27: pat = 8'h73;
         6'd28: pat = 8'h6B;
         6'd29: pat = 8'h50;
         6'd30: pat = 8'h6D;
         6'd31: pat = 8'h78;
         6'd32: pat = 8'h1C;
         6'd33: pat = 8'h1C;
         6'd34: pat = 8'h2A;
         6'd35: pat = 8'h76;
         6'd36: pat = 8'h6E;
         6'd37: pat = 8'h5B;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // quotient by ten through the reciprocal 205/2048, exact below 1029
   function automatic logic [6:0] div10(input logic [9:0] v);
      logic [17:0] prod;
      prod = 18'(v) * 18'd205;
      return prod[17:11];
   endfunction

   function automatic logic [3:0] rem10(input logic [9:0] v, input logic [6:0] q);
      logic [9:0] tens;
      tens = 10'(q) * 10'd10;
      return 4'(v - tens);
   endfunction

endpackage

// ===== hdl/three_digit_status_display.sv =====
// ----------------------------------------------------------------------------
// three_digit_status_display
// Multiplexed three-digit seven-segment driver with status screens.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | moves
//  req     | req_valid req_stall req_data   | in        | one tick item
//  rsp     | rsp_valid rsp_stall rsp_data   | out       | one digit item
//  csr     | csr_write csr_index csr_wdata  | in        | register write
//
//  one item per clock while rsp_stall is low; an accepted item passes
//  through the input register, then the result register, to rsp
//  all display state is updated in the single pass between the two registers
//  reset: synchronous, clears control state, loads register defaults
//  rsp_stall holds the result register; req_stall rises only when both
//  registers are full and the result is not taken
// ----------------------------------------------------------------------------
module three_digit_status_display (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdsd_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tdsd_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int HB = tdsd_pkg::HOLD_COUNTER_BITS;
   localparam int CB = tdsd_pkg::HOLD_CMP_BITS;

   logic [15:0] warn_hold_ff, show_hold_ff;
   logic [9:0]  high_limit_ff, low_limit_ff;

   logic              in_valid_ff, in_valid_in;
   tdsd_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   tdsd_pkg::rsp_type out_data_ff, out_data_in;

   tdsd_pkg::screen_type screen_ff, screen_in;
   logic [HB-1:0] hold_ff, hold_in, hold_inc;
   logic [6:0]    last_duty_ff, last_duty_in;
   logic [1:0]    scan_ff, scan_in;
   logic [7:0]    pat_ff [3];
   logic [7:0]    pat_in [3];

   logic advance, accept;
   logic [9:0] volt;
   logic [6:0] duty;
   logic [3:0] power;
   logic [6:0] v1, duty_tens;
   logic [3:0] v2, d0, d1, duty_ones;
   logic [CB-1:0] hold_cmp, warn_cmp, show_cmp;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   // saturation and decimal digits
   always_comb begin
      volt = (in_data_ff.volt_tenths > tdsd_pkg::VOLT_MAX) ?
             tdsd_pkg::VOLT_MAX : in_data_ff.volt_tenths;
      duty = (in_data_ff.duty_percent > tdsd_pkg::DUTY_MAX) ?
             tdsd_pkg::DUTY_MAX : in_data_ff.duty_percent;
      power = (in_data_ff.power_level > tdsd_pkg::POWER_MAX) ?
              tdsd_pkg::POWER_MAX : in_data_ff.power_level;
      v1 = tdsd_pkg::div10(volt);
      d0 = tdsd_pkg::rem10(volt, v1);
      v2 = 4'(tdsd_pkg::div10(10'(v1)));
      d1 = tdsd_pkg::rem10(10'(v1), 7'(v2));
      duty_tens = tdsd_pkg::div10(10'(duty));
      duty_ones = tdsd_pkg::rem10(10'(duty), duty_tens);
   end

   always_comb begin
      hold_inc = (hold_ff == {HB{1'b1}}) ? hold_ff : hold_ff + 1'b1;
      hold_cmp = CB'(hold_inc);
      warn_cmp = CB'(warn_hold_ff);
      show_cmp = CB'(show_hold_ff);
      screen_in = screen_ff;
      hold_in = hold_inc;
      last_duty_in = last_duty_ff;
      pat_in = pat_ff;
      case (in_data_ff.panel_mode)
         tdsd_pkg::MODE_NORMAL: begin
            case (screen_ff)
               tdsd_pkg::SCREEN_HIGH, tdsd_pkg::SCREEN_LOW: begin
                  if (screen_ff == tdsd_pkg::SCREEN_HIGH) begin
                     pat_in[0] = tdsd_pkg::font(tdsd_pkg::FONT_H);
                     pat_in[1] = tdsd_pkg::font(tdsd_pkg::FONT_I);
                  end else begin
                     pat_in[0] = tdsd_pkg::font(tdsd_pkg::FONT_L);
                     pat_in[1] = tdsd_pkg::font(tdsd_pkg::FONT_O);
                  end
                  pat_in[2] = tdsd_pkg::font(tdsd_pkg::FONT_BLANK);
                  if (hold_cmp > warn_cmp) begin
                     screen_in = tdsd_pkg::SCREEN_VOLT;
                     hold_in = '0;
                  end
               end
               tdsd_pkg::SCREEN_DUTY: begin
                  pat_in[0] = tdsd_pkg::font(tdsd_pkg::FONT_D);
                  pat_in[1] = tdsd_pkg::font(6'(duty_tens));
                  pat_in[2] = tdsd_pkg::font(6'(duty_ones));
                  if (duty != last_duty_ff) begin
                     last_duty_in = duty;
                     hold_in = '0;
                  end else if (hold_cmp > show_cmp) begin
                     screen_in = tdsd_pkg::SCREEN_VOLT;
                     hold_in = '0;
                  end
               end
               default: begin
                  pat_in[0] = tdsd_pkg::font((v2 != 4'd0) ? 6'(v2) : tdsd_pkg::FONT_BLANK);
                  pat_in[1] = tdsd_pkg::font((v1 != 7'd0) ? 6'(d1) : tdsd_pkg::FONT_BLANK)
                              | tdsd_pkg::font(tdsd_pkg::FONT_DOT);
                  pat_in[2] = tdsd_pkg::font((volt != 10'd0) ? 6'(d0) : tdsd_pkg::FONT_BLANK);
                  if (hold_cmp > show_cmp) begin
                     if (volt > high_limit_ff) begin
                        screen_in = tdsd_pkg::SCREEN_HIGH;
                     end else if (volt < low_limit_ff) begin
                        screen_in = tdsd_pkg::SCREEN_LOW;
                     end else begin
                        screen_in = tdsd_pkg::SCREEN_DUTY;
                     end
                     hold_in = '0;
                  end
               end
            endcase
         end
         tdsd_pkg::MODE_LEVEL: begin
            pat_in[0] = tdsd_pkg::font(tdsd_pkg::FONT_P);
            pat_in[1] = tdsd_pkg::font(tdsd_pkg::FONT_DASH);
            pat_in[2] = tdsd_pkg::font(6'(power));
         end
         tdsd_pkg::MODE_PULSE: begin
            pat_in[0] = tdsd_pkg::font(tdsd_pkg::FONT_S);
            pat_in[1] = tdsd_pkg::font(tdsd_pkg::FONT_DASH);
            pat_in[2] = tdsd_pkg::font(6'(in_data_ff.pulse_count[3:1]) + 6'd1);
         end
         default: begin
         end
      endcase

      // scan out
      out_data_in.segments = 8'h00;
      out_data_in.digit_enable_n = 3'b111;
      scan_in = 2'd0;
      case (scan_ff)
         2'd0: begin
            out_data_in.segments = pat_in[0];
            out_data_in.digit_enable_n = 3'b110;
            scan_in = 2'd1;
         end
         2'd1: begin
            out_data_in.segments = pat_in[1];
            out_data_in.digit_enable_n = 3'b101;
            scan_in = tdsd_pkg::SCAN_LAST;
         end
         tdsd_pkg::SCAN_LAST: begin
            out_data_in.segments = pat_in[2];
            out_data_in.digit_enable_n = 3'b011;
            scan_in = 2'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_hold_ff <= tdsd_pkg::WARN_HOLD_RESET;
         show_hold_ff <= tdsd_pkg::SHOW_HOLD_RESET;
         high_limit_ff <= tdsd_pkg::HIGH_LIMIT_RESET;
         low_limit_ff <= tdsd_pkg::LOW_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tdsd_pkg::CSR_WARN_HOLD: warn_hold_ff <= csr_wdata;
            tdsd_pkg::CSR_SHOW_HOLD: show_hold_ff <= csr_wdata;
            tdsd_pkg::CSR_HIGH_LIMIT: high_limit_ff <= csr_wdata[9:0];
            tdsd_pkg::CSR_LOW_LIMIT: low_limit_ff <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         screen_ff <= tdsd_pkg::SCREEN_VOLT;
         hold_ff <= '0;
         last_duty_ff <= '0;
         scan_ff <= '0;
         pat_ff[0] <= tdsd_pkg::PATTERN0_RESET;
         pat_ff[1] <= tdsd_pkg::PATTERN1_RESET;
         pat_ff[2] <= tdsd_pkg::PATTERN2_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            screen_ff <= screen_in;
            hold_ff <= hold_in;
            last_duty_ff <= last_duty_in;
            scan_ff <= scan_in;
            pat_ff <= pat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff != 2'd3) else $error("scan digit out of range");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_data.digit_enable_n) == 2)
      else $error("not exactly one digit enabled");

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff) else $error("pending item lost");

   a_out_filled: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff) else $error("result register not filled");

   a_hold_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && screen_in != screen_ff) |=> hold_ff == '0)
      else $error("hold counter not cleared on screen change");

endmodule

// ===== dv/three_digit_status_display_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_digit_status_display_checker
// Watches the tick, digit and register ports of the status display, keeps its
// own model of screens, hold timer, pattern buffer and scan, and compares each
// digit item leaving the block with the one predicted for it.
// ----------------------------------------------------------------------------
module three_digit_status_display_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  tdsd_pkg::req_type   req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  tdsd_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output int unsigned         error_count,
   output int unsigned         digits_pending,
   output int unsigned         digits_checked,
   output logic [3:0]          screens_seen
);

   localparam int unsigned PRINT_LIMIT = 100;

   // seven-segment glyphs, element 0 leftmost
   localparam logic [0:38][7:0] GLYPHS = {
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h40, 8'h80,
      8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E, 8'h75,
      8'h38, 8'h37, 8'h54, 8'h5C, 8'h73, 8'h6B, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C,
      8'h2A, 8'h76, 8'h6E, 8'h5B,
      8'h00
   };

   logic [15:0] warn_hold;
   logic [15:0] show_hold;
   logic [9:0] high_limit;
   logic [9:0] low_limit;

   tdsd_pkg::screen_type screen;
   logic [tdsd_pkg::HOLD_COUNTER_BITS-1:0] hold_count;
   logic [6:0] duty_seen;
   logic [1:0] scan_pos;
   logic [7:0] pattern [0:2];

   tdsd_pkg::rsp_type digit_queue [$];
   tdsd_pkg::rsp_type predicted;
   tdsd_pkg::rsp_type oldest;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // one tick: refresh the pattern buffer, then drive the current digit
   task automatic predict_digit(input tdsd_pkg::req_type tick,
                                output tdsd_pkg::rsp_type shown);
      logic [9:0] volt;
      logic [9:0] v;
      logic [6:0] duty;
      logic [3:0] power;
      int k;
      volt = (tick.volt_tenths > tdsd_pkg::VOLT_MAX) ?
             tdsd_pkg::VOLT_MAX : tick.volt_tenths;
      duty = (tick.duty_percent > tdsd_pkg::DUTY_MAX) ?
             tdsd_pkg::DUTY_MAX : tick.duty_percent;
      power = (tick.power_level > tdsd_pkg::POWER_MAX) ?
              tdsd_pkg::POWER_MAX : tick.power_level;

      if (hold_count != '1)
         hold_count = hold_count + 1'b1;

      case (tick.panel_mode)
         tdsd_pkg::MODE_NORMAL: begin
            case (screen)
               tdsd_pkg::SCREEN_HIGH, tdsd_pkg::SCREEN_LOW: begin
                  if (screen == tdsd_pkg::SCREEN_HIGH) begin
                     pattern[0] = GLYPHS[tdsd_pkg::FONT_H];
                     pattern[1] = GLYPHS[tdsd_pkg::FONT_I];
                  end else begin
                     pattern[0] = GLYPHS[tdsd_pkg::FONT_L];
                     pattern[1] = GLYPHS[tdsd_pkg::FONT_O];
                  end
                  pattern[2] = GLYPHS[tdsd_pkg::FONT_BLANK];
                  if (hold_count > warn_hold) begin
                     screen = tdsd_pkg::SCREEN_VOLT;
                     hold_count = '0;
                  end
               end
               tdsd_pkg::SCREEN_DUTY: begin
                  pattern[0] = GLYPHS[tdsd_pkg::FONT_D];
                  pattern[1] = GLYPHS[duty / 10];
                  pattern[2] = GLYPHS[duty % 10];
                  // a new duty value restarts the hold
                  if (duty != duty_seen) begin
                     duty_seen = duty;
                     hold_count = '0;
                  end
                  if (hold_count > show_hold) begin
                     screen = tdsd_pkg::SCREEN_VOLT;
                     hold_count = '0;
                  end
               end
               default: begin
                  v = volt;
                  for (k = 2; k >= 0; k--) begin
                     pattern[k] = (v != 0) ? GLYPHS[v % 10] : GLYPHS[tdsd_pkg::FONT_BLANK];
                     v = v / 10;
                  end
                  pattern[1] = pattern[1] | GLYPHS[tdsd_pkg::FONT_DOT];
                  if (hold_count > show_hold) begin
                     if (volt > high_limit)
                        screen = tdsd_pkg::SCREEN_HIGH;
                     else if (volt < low_limit)
                        screen = tdsd_pkg::SCREEN_LOW;
                     else
                        screen = tdsd_pkg::SCREEN_DUTY;
                     hold_count = '0;
                  end
               end
            endcase
            screens_seen[screen] = 1'b1;
         end
         tdsd_pkg::MODE_LEVEL: begin
            pattern[0] = GLYPHS[tdsd_pkg::FONT_P];
            pattern[1] = GLYPHS[tdsd_pkg::FONT_DASH];
            pattern[2] = GLYPHS[power];
         end
         tdsd_pkg::MODE_PULSE: begin
            pattern[0] = GLYPHS[tdsd_pkg::FONT_S];
            pattern[1] = GLYPHS[tdsd_pkg::FONT_DASH];
            pattern[2] = GLYPHS[tick.pulse_count / 2 + 1];
         end
         default: ;
      endcase

      if (scan_pos <= tdsd_pkg::SCAN_LAST) begin
         shown.segments = pattern[scan_pos];
         shown.digit_enable_n = ~(3'b001 << scan_pos);
         scan_pos = (scan_pos == tdsd_pkg::SCAN_LAST) ? 2'd0 : scan_pos + 1'b1;
      end else begin
         shown.segments = 8'h00;
         shown.digit_enable_n = 3'b111;
         scan_pos = 2'd0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         warn_hold = tdsd_pkg::WARN_HOLD_RESET;
         show_hold = tdsd_pkg::SHOW_HOLD_RESET;
         high_limit = tdsd_pkg::HIGH_LIMIT_RESET;
         low_limit = tdsd_pkg::LOW_LIMIT_RESET;
         screen = tdsd_pkg::SCREEN_VOLT;
         hold_count = '0;
         duty_seen = '0;
         scan_pos = '0;
         pattern[0] = tdsd_pkg::PATTERN0_RESET;
         pattern[1] = tdsd_pkg::PATTERN1_RESET;
         pattern[2] = tdsd_pkg::PATTERN2_RESET;
         digit_queue.delete();
         error_count = 0;
         digits_checked = 0;
         screens_seen = '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               tdsd_pkg::CSR_WARN_HOLD: warn_hold = csr_wdata;
               tdsd_pkg::CSR_SHOW_HOLD: show_hold = csr_wdata;
               tdsd_pkg::CSR_HIGH_LIMIT: high_limit = csr_wdata[9:0];
               tdsd_pkg::CSR_LOW_LIMIT: low_limit = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_digit(req_data, predicted);
            digit_queue.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digit_queue.size() == 0) begin
               report_mismatch("digit item with none expected", rsp_data, 0);
            end else begin
               oldest = digit_queue.pop_front();
               if (rsp_data.segments !== oldest.segments)
                  report_mismatch("segments", rsp_data.segments, oldest.segments);
               if (rsp_data.digit_enable_n !== oldest.digit_enable_n)
                  report_mismatch("digit_enable_n", rsp_data.digit_enable_n,
                                  oldest.digit_enable_n);
               digits_checked++;
            end
         end
      end
      digits_pending = digit_queue.size();
   end

endmodule

// ===== dv/three_digit_status_display_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_digit_status_display_test
// Drives timer ticks and register settings into the status display under
// several idle and stall patterns; the checker beside the block predicts and
// compares every digit item, and this module gives the verdict.
// ----------------------------------------------------------------------------
module three_digit_status_display_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tdsd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tdsd_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = tdsd_pkg::CSR_WARN_HOLD;
   logic [15:0] csr_wdata = '0;

   int unsigned error_count;
   int unsigned digits_pending;
   int unsigned digits_checked;
   logic [3:0] screens_seen;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_off_asked = 0;
   int unsigned hold_off_done = 0;
   int unsigned ticks_sent = 0;
   int unsigned settings_loaded = 0;
   int unsigned quiet_cycles = 0;
   logic [9:0] steady_volt = 10'd250;
   logic [6:0] steady_duty = 7'd40;

   three_digit_status_display uut (.*);

   three_digit_status_display_checker checker_i (.*);

   always #4 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_asked != hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_tick(input tdsd_pkg::req_type tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic drain_digits();
      req_valid <= 1'b0;
      @(negedge clock);
      while (digits_pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] warn, input logic [15:0] show,
                                input logic [9:0] high, input logic [9:0] low);
      drain_digits();
      csr_write <= 1'b1;
      csr_index <= tdsd_pkg::CSR_WARN_HOLD;
      csr_wdata <= warn;
      @(negedge clock);
      csr_index <= tdsd_pkg::CSR_SHOW_HOLD;
      csr_wdata <= show;
      @(negedge clock);
      csr_index <= tdsd_pkg::CSR_HIGH_LIMIT;
      csr_wdata <= 16'(high);
      @(negedge clock);
      csr_index <= tdsd_pkg::CSR_LOW_LIMIT;
      csr_wdata <= 16'(low);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      settings_loaded++;
   endtask

   // voltage and duty mostly steady so that the hold timers can run out
   function automatic tdsd_pkg::req_type random_tick();
      tdsd_pkg::req_type tick;
      int unsigned pick;
      if ($urandom_range(99) < 10)
         steady_volt = ($urandom_range(1) == 0) ? 10'($urandom) : 10'($urandom_range(400));
      if ($urandom_range(99) < 8)
         steady_duty = 7'($urandom);
      tick.volt_tenths = steady_volt;
      tick.duty_percent = steady_duty;
      tick.power_level = 4'($urandom);
      tick.pulse_count = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 76)
         tick.panel_mode = tdsd_pkg::MODE_NORMAL;
      else if (pick < 84)
         tick.panel_mode = tdsd_pkg::MODE_LEVEL;
      else if (pick < 92)
         tick.panel_mode = tdsd_pkg::MODE_PULSE;
      else
         tick.panel_mode = MODE_UNUSED;
      return tick;
   endfunction

   task automatic run_phase(input logic [15:0] warn, input logic [15:0] show,
                            input logic [9:0] high, input logic [9:0] low,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input bit hold_off, input int unsigned count);
      int unsigned n;
      load_settings(warn, show, high, low);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      if (hold_off)
         hold_off_asked++;
      for (n = 0; n < count; n++) begin
         if (n == count / 2)
            drain_digits();
         send_tick(random_tick());
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset pattern buffer, voltage formats, saturation, panel modes
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd0, MODE_UNUSED});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd0, MODE_UNUSED});
      send_tick(tdsd_pkg::req_type'{10'd1023, 7'd127, 4'd15, 4'd15, MODE_UNUSED});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd5, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd47, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd100, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd999, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd1023, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_LEVEL});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd9, 4'd0, tdsd_pkg::MODE_LEVEL});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd15, 4'd0, tdsd_pkg::MODE_LEVEL});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_PULSE});
      send_tick(tdsd_pkg::req_type'{10'd0, 7'd0, 4'd0, 4'd15, tdsd_pkg::MODE_PULSE});

      // short holds: walk through the warning and duty screens
      load_settings(16'd1, 16'd1, 10'd340, 10'd200);
      send_tick(tdsd_pkg::req_type'{10'd350, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd350, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd350, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd150, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd150, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd150, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd150, 7'd50, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd127, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd127, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd127, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});
      send_tick(tdsd_pkg::req_type'{10'd250, 7'd0, 4'd0, 4'd0, tdsd_pkg::MODE_NORMAL});

      run_phase(16'd3, 16'd6, 10'd340, 10'd200, 0, 0, 1'b0, 250);
      run_phase(16'd0, 16'd0, 10'd500, 10'd100, 68, 0, 1'b0, 200);
      run_phase(16'd10, 16'd20, 10'd999, 10'd0, 0, 68, 1'b1, 250);
      run_phase(16'd5, 16'd4, 10'd0, 10'd999, 27, 27, 1'b0, 200);
      run_phase(16'd65535, 16'd2, 10'd340, 10'd200, 0, 0, 1'b0, 150);
      run_phase(16'd2, 16'd65535, 10'd600, 10'd300, 68, 0, 1'b0, 120);
      run_phase(16'd7, 16'd9, 10'd300, 10'd250, 0, 68, 1'b1, 250);
      run_phase(16'd4, 16'd3, 10'd450, 10'd150, 27, 27, 1'b0, 200);

      drain_digits();
      repeat (8) @(negedge clock);
      $display("%0d ticks over %0d register settings, %0d digit items checked",
               ticks_sent, settings_loaded, digits_checked);
      $display("normal screens reached (low, high, duty, voltage): %b", screens_seen);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tdsd_pkg.sv
hdl/three_digit_status_display.sv
dv/three_digit_status_display_checker.sv
dv/three_digit_status_display_test.sv
